// ----- sv/cia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cia_pkg;

    // default pool size and fixed field widths
    localparam int POOL_SIZE_DEF = 32;
    localparam int STATUS_W      = 3;
    localparam int GRANT_W       = 5;
    localparam int CHAN_W        = 6;

    // request codes
    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 3'd4;

    // request item
    typedef struct packed {
        logic              func;
        logic [CHAN_W-1:0] channel;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [GRANT_W-1:0]  granted_index;
    } t_out_item;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_HOLD
    } t_state;

endpackage

`default_nettype wire

// ----- sv/cia_stack_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cia_stack_mem #(
    parameter int DEPTH = cia_pkg::POOL_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/cia_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cia_ctrl #(
    parameter int POOL_SIZE = cia_pkg::POOL_SIZE_DEF,
    parameter int IDX_W     = $clog2(POOL_SIZE),
    parameter int CNT_W     = $clog2(POOL_SIZE + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request side
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire cia_pkg::t_in_item i_in,
    // finished result toward the output register
    output logic                   o_res_valid,
    output cia_pkg::t_out_item     o_res,
    input  wire logic              i_res_take,
    // free stack memory
    output logic                   o_wr_en,
    output logic [IDX_W-1:0]       o_wr_addr,
    output logic [IDX_W-1:0]       o_wr_data,
    output logic                   o_rd_en,
    output logic [IDX_W-1:0]       o_rd_addr,
    input  wire logic [IDX_W-1:0]  i_rd_data
);

    localparam logic [CNT_W-1:0]          POOL_CNT = CNT_W'(POOL_SIZE);
    localparam logic [cia_pkg::CHAN_W:0]  POOL_LIM = (cia_pkg::CHAN_W + 1)'(POOL_SIZE);

    cia_pkg::t_state    r_state, n_state;
    logic [CNT_W-1:0]   r_depth, n_depth;
    logic [CNT_W-1:0]   r_hw, n_hw;
    logic [POOL_SIZE-1:0] r_busy, n_busy;
    cia_pkg::t_out_item r_pend, n_pend;

    logic                accept;
    logic                in_range;
    logic [IDX_W-1:0]    chan_idx;
    logic [IDX_W-1:0]    hw_idx;
    logic [IDX_W+4:0]    hw_ext;
    logic [IDX_W+4:0]    pop_ext;

    assign accept   = i_in_valid && (r_state == cia_pkg::S_IDLE);
    assign in_range = {1'b0, i_in.channel} < POOL_LIM;
    assign chan_idx = i_in.channel[IDX_W-1:0];
    assign hw_idx   = r_hw[IDX_W-1:0];
    assign hw_ext   = {5'b0, hw_idx};
    assign pop_ext  = {5'b0, i_rd_data};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cia_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.func == cia_pkg::FUNC_ALLOC && r_depth != '0) begin
                        n_state = cia_pkg::S_POP;
                    end else begin
                        n_state = cia_pkg::S_HOLD;
                    end
                end
            end
            cia_pkg::S_POP: begin
                n_state = cia_pkg::S_HOLD;
            end
            cia_pkg::S_HOLD: begin
                if (i_res_take) begin
                    n_state = cia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cia_pkg::S_IDLE;
            end
        endcase
    end

    // datapath, memory ports and handshake
    always_comb begin
        n_depth   = r_depth;
        n_hw      = r_hw;
        n_busy    = r_busy;
        n_pend    = r_pend;
        o_wr_en   = 1'b0;
        o_wr_addr = r_depth[IDX_W-1:0];
        o_wr_data = chan_idx;
        o_rd_en   = 1'b0;
        o_rd_addr = IDX_W'(r_depth - CNT_W'(1));
        case (r_state)
            cia_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.func == cia_pkg::FUNC_ALLOC) begin
                        if (r_depth != '0) begin
                            // pop the most recently freed index
                            o_rd_en = 1'b1;
                            n_depth = r_depth - CNT_W'(1);
                        end else if (r_hw < POOL_CNT) begin
                            // issue a never-used index
                            n_pend.status        = cia_pkg::ST_GRANTED;
                            n_pend.granted_index = hw_ext[4:0];
                            n_busy[hw_idx]       = 1'b1;
                            n_hw                 = r_hw + CNT_W'(1);
                        end else begin
                            n_pend.status        = cia_pkg::ST_NONE_FREE;
                            n_pend.granted_index = '0;
                        end
                    end else begin
                        n_pend.granted_index = '0;
                        if (!in_range) begin
                            n_pend.status = cia_pkg::ST_OUT_OF_RANGE;
                        end else if (!r_busy[chan_idx] || r_depth >= POOL_CNT) begin
                            n_pend.status = cia_pkg::ST_NOT_ALLOCATED;
                        end else begin
                            // push the index back onto the free stack
                            n_pend.status    = cia_pkg::ST_RELEASED;
                            n_busy[chan_idx] = 1'b0;
                            o_wr_en          = 1'b1;
                            n_depth          = r_depth + CNT_W'(1);
                        end
                    end
                end
            end
            cia_pkg::S_POP: begin
                // popped index arrives from the memory
                n_pend.status        = cia_pkg::ST_GRANTED;
                n_pend.granted_index = pop_ext[4:0];
                n_busy[i_rd_data]    = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall  = (r_state != cia_pkg::S_IDLE);
    assign o_res_valid = (r_state == cia_pkg::S_HOLD);
    assign o_res       = r_pend;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cia_pkg::S_IDLE;
            r_depth <= '0;
            r_hw    <= '0;
            r_busy  <= '0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_hw    <= n_hw;
            r_busy  <= n_busy;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

endmodule

`default_nettype wire

// ----- sv/channel_index_allocator.sv -----
// channel   direction  handshake               payload
// request   in         i_in_valid / o_in_stall  i_in  (func, channel)
// result    out        o_out_valid / i_out_stall o_out (status, granted_index)
//
// one item in flight: after a request is accepted, the next is taken only once
// its result has moved into the output register; an allocate that pops the free
// stack passes through S_POP first, since the stack memory read is registered
// the result sits in an output register, so a stalled result does not block
// the next request; only a second finished result waits on the output
// synchronous reset clears the stack depth, the high-water counter and the
// busy map; the stack memory is not cleared and holds no valid entry after it
`timescale 1ns / 1ps
`default_nettype none

module channel_index_allocator #(
    parameter int POOL_SIZE = cia_pkg::POOL_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire cia_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output cia_pkg::t_out_item      o_out
);

    localparam int IDX_W = $clog2(POOL_SIZE);
    localparam int CNT_W = $clog2(POOL_SIZE + 1);

    logic               res_valid;
    logic               res_take;
    cia_pkg::t_out_item res;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   rd_data;
    logic               r_out_valid;
    cia_pkg::t_out_item r_out;

    // allocation control
    cia_ctrl #(
        .POOL_SIZE (POOL_SIZE),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    // free stack storage
    cia_stack_mem #(
        .DEPTH (POOL_SIZE),
        .AW    (IDX_W),
        .DW    (IDX_W)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register takes a result when empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- sv/cia_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cia_checker #(
    parameter int POOL_SIZE = cia_pkg::POOL_SIZE_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire cia_pkg::t_out_item o_out
);

    localparam logic [cia_pkg::CHAN_W:0] POOL_LIM = (cia_pkg::CHAN_W + 1)'(POOL_SIZE);

    // one item at a time: an accepted item blocks the next cycle
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted back to back");

    // a granted index lies inside the pool
    a_grant_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == cia_pkg::ST_GRANTED)
            |-> ({2'b0, o_out.granted_index} < POOL_LIM || POOL_SIZE > 32))
        else $error("granted index outside pool");

    // only a grant carries an index
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != cia_pkg::ST_GRANTED)
            |-> (o_out.granted_index == '0))
        else $error("index on a non-grant result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

endmodule

bind channel_index_allocator cia_checker #(
    .POOL_SIZE (POOL_SIZE)
) u_cia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

// ----- dv/channel_index_allocator_checker.sv -----
`timescale 1ns / 1ps

module channel_index_allocator_checker #(
    parameter int POOL_SIZE = cia_pkg::POOL_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire cia_pkg::t_in_item  i_in,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire cia_pkg::t_out_item i_out,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results,
    output int                      o_none_free,
    output int                      o_peak_depth
);

    // mirror of the allocator state
    int          free_stack [POOL_SIZE];
    int          stack_depth;
    int          high_water;
    logic [63:0] busy_map;

    // expected results, oldest first
    cia_pkg::t_out_item expected_results [$];

    // one request in, one result out, state updated in place
    function automatic cia_pkg::t_out_item allocate_or_release(input cia_pkg::t_in_item req);
        cia_pkg::t_out_item res;
        int                 idx;
        res.status        = cia_pkg::ST_NOT_ALLOCATED;
        res.granted_index = '0;
        idx               = int'(req.channel);
        if (req.func == cia_pkg::FUNC_ALLOC) begin
            if (stack_depth > 0) begin
                // most recently freed index goes out first
                stack_depth--;
                idx               = free_stack[stack_depth];
                busy_map[idx]     = 1'b1;
                res.granted_index = idx[cia_pkg::GRANT_W-1:0];
                res.status        = cia_pkg::ST_GRANTED;
            end else if (high_water < POOL_SIZE) begin
                // fresh index from the high-water counter
                idx               = high_water;
                high_water++;
                busy_map[idx]     = 1'b1;
                res.granted_index = idx[cia_pkg::GRANT_W-1:0];
                res.status        = cia_pkg::ST_GRANTED;
            end else begin
                res.status = cia_pkg::ST_NONE_FREE;
            end
        end else begin
            if (idx >= POOL_SIZE) begin
                res.status = cia_pkg::ST_OUT_OF_RANGE;
            end else if (!busy_map[idx] || stack_depth >= POOL_SIZE) begin
                res.status = cia_pkg::ST_NOT_ALLOCATED;
            end else begin
                busy_map[idx]           = 1'b0;
                free_stack[stack_depth] = idx;
                stack_depth++;
                res.status              = cia_pkg::ST_RELEASED;
            end
        end
        return res;
    endfunction

    // watch both channels at the rising edge
    always @(posedge i_clk) begin : watch
        cia_pkg::t_out_item want;
        if (!i_rst_n) begin
            stack_depth  = 0;
            high_water   = 0;
            busy_map     = '0;
            o_fail_count = 0;
            o_results    = 0;
            o_none_free  = 0;
            o_peak_depth = 0;
            expected_results.delete();
        end else begin
            // compare an accepted result with the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting: status %0d, granted_index %0d",
                           i_out.status, i_out.granted_index);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_out.status);
                        o_fail_count++;
                    end
                    if (i_out.granted_index !== want.granted_index) begin
                        $error("granted_index: expected %0d, actual %0d",
                               want.granted_index, i_out.granted_index);
                        o_fail_count++;
                    end
                end
            end
            // predict the result of an accepted request
            if (i_in_valid && !i_in_stall) begin
                want = allocate_or_release(i_in);
                if (want.status == cia_pkg::ST_NONE_FREE) begin
                    o_none_free++;
                end
                if (stack_depth > o_peak_depth) begin
                    o_peak_depth = stack_depth;
                end
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- dv/channel_index_allocator_tb.sv -----
`timescale 1ns / 1ps

module channel_index_allocator_tb;

    localparam int POOL_SIZE    = cia_pkg::POOL_SIZE_DEF;
    localparam int RANDOM_ITEMS = 1100;

    logic               i_clk;
    logic               i_rst_n;
    logic               req_valid;
    logic               req_stall;
    cia_pkg::t_in_item  req_item;
    logic               res_valid;
    logic               res_stall;
    cia_pkg::t_out_item res_item;

    int          fail_count;
    int          pending_count;
    int          result_count;
    int          none_free_count;
    int          peak_depth;
    int          alloc_sent;
    int          release_sent;

    int          random_sent;
    int          block_len;
    int          alloc_pct;
    int          burst_left;
    logic        pick_func;
    logic [5:0]  pick_chan;

    channel_index_allocator #(
        .POOL_SIZE (POOL_SIZE)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in        (req_item),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out       (res_item)
    );

    channel_index_allocator_checker #(
        .POOL_SIZE (POOL_SIZE)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_in         (req_item),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_out        (res_item),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_results    (result_count),
        .o_none_free  (none_free_count),
        .o_peak_depth (peak_depth)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver stall: spans of free flow, light, heavy and alternating stall
    initial begin : stall_gen
        int mode;
        int span;
        res_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: begin
                        res_stall <= 1'b0;
                    end
                    1: begin
                        res_stall <= ($urandom_range(0, 99) < 30);
                    end
                    2: begin
                        res_stall <= ($urandom_range(0, 99) < 70);
                    end
                    default: begin
                        res_stall <= ~res_stall;
                    end
                endcase
            end
        end
    end

    // present one item and hold it until accepted
    task automatic send_request(input logic func, input logic [cia_pkg::CHAN_W-1:0] chan);
        cia_pkg::t_in_item item;
        item.func    = func;
        item.channel = chan;
        @(negedge i_clk);
        req_valid <= 1'b1;
        req_item  <= item;
        do begin
            @(posedge i_clk);
        end while (req_stall);
        if (func == cia_pkg::FUNC_ALLOC) begin
            alloc_sent++;
        end else begin
            release_sent++;
        end
    endtask

    // drop valid for a number of cycles
    task automatic idle_for(input int cycles);
        @(negedge i_clk);
        req_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // hold off until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        req_valid <= 1'b0;
        wait (pending_count == 0);
    endtask

    // stimulus
    initial begin
        i_rst_n      = 1'b0;
        req_valid    = 1'b0;
        req_item     = '0;
        alloc_sent   = 0;
        release_sent = 0;
        random_sent  = 0;
        burst_left   = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: releases before anything is issued, range edges
        send_request(cia_pkg::FUNC_RELEASE, 6'd0);
        send_request(cia_pkg::FUNC_RELEASE, 6'd63);
        send_request(cia_pkg::FUNC_RELEASE, 6'd32);
        send_request(cia_pkg::FUNC_RELEASE, 6'd31);
        // directed: counter grants, channel field ignored on allocate
        send_request(cia_pkg::FUNC_ALLOC, 6'd63);
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        send_request(cia_pkg::FUNC_ALLOC, 6'd21);
        // directed: release, double release, then last-in first-out pops
        send_request(cia_pkg::FUNC_RELEASE, 6'd1);
        send_request(cia_pkg::FUNC_RELEASE, 6'd1);
        send_request(cia_pkg::FUNC_RELEASE, 6'd2);
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        send_request(cia_pkg::FUNC_RELEASE, 6'd0);
        send_request(cia_pkg::FUNC_RELEASE, 6'd3);
        send_request(cia_pkg::FUNC_RELEASE, 6'd2);
        send_request(cia_pkg::FUNC_ALLOC, 6'd42);
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        drain_results();

        // fill the pool to exhaustion, then free the top index
        repeat (POOL_SIZE + 4) begin
            send_request(cia_pkg::FUNC_ALLOC, 6'($urandom_range(0, 63)));
        end
        send_request(cia_pkg::FUNC_RELEASE, 6'(POOL_SIZE - 1));
        send_request(cia_pkg::FUNC_ALLOC, 6'd0);
        drain_results();

        // random blocks: allocate heavy, balanced, or release heavy
        while (random_sent < RANDOM_ITEMS) begin
            block_len = $urandom_range(30, 120);
            if (block_len > RANDOM_ITEMS - random_sent) begin
                block_len = RANDOM_ITEMS - random_sent;
            end
            case ($urandom_range(0, 2))
                0:       alloc_pct = 90;
                1:       alloc_pct = 50;
                default: alloc_pct = 10;
            endcase
            repeat (block_len) begin
                // bursts with random gaps, some back to back
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0) begin
                        idle_for($urandom_range(1, 8));
                    end
                end
                burst_left--;
                if ($urandom_range(0, 99) < alloc_pct) begin
                    pick_func = cia_pkg::FUNC_ALLOC;
                    pick_chan = 6'($urandom_range(0, 63));
                end else begin
                    pick_func = cia_pkg::FUNC_RELEASE;
                    if ($urandom_range(0, 99) < 85) begin
                        pick_chan = 6'($urandom_range(0, POOL_SIZE - 1));
                    end else begin
                        pick_chan = 6'($urandom_range(POOL_SIZE, 63));
                    end
                end
                send_request(pick_func, pick_chan);
                random_sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                drain_results();
            end
        end

        // let the pipeline empty
        drain_results();
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests (%0d allocate, %0d release), %0d results checked",
                 alloc_sent + release_sent, alloc_sent, release_sent, result_count);
        $display("pool ran dry %0d times, free stack reached depth %0d",
                 none_free_count, peak_depth);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
